[rtl/cdn_pkg.sv]
// Shared types and constants for the calendar day number converter.
// Depends on nothing; imported by the converter top level.
package cdn_pkg;

	// Command codes
	localparam logic CMD_DATE_TO_JDN = 1'b0;
	localparam logic CMD_JDN_TO_DATE = 1'b1;

	// Supported day number window for the reverse conversion
	localparam logic [22:0] JDN_MIN = 23'd1721120;   // 0000-03-01
	localparam logic [22:0] JDN_MAX = 23'd5373484;   // 9999-12-31

	// Forward conversion constants
	localparam logic [14:0] YEAR_BIAS = 15'd4800;
	localparam logic [23:0] EPOCH_OFS = 24'd32045;

	// 4 * 1721119 + 1: turns a day number into 4j - 1
	localparam logic [24:0] X_OFFSET = 25'd6884477;

	// Period lengths in days
	localparam logic [18:0] DAYS_400Y = 19'd146097;
	localparam logic [11:0] DAYS_4Y   = 12'd1461;
	localparam logic [8:0]  DAYS_5M   = 9'd153;

	// Reciprocals (2^s / divisor; ceiling for 25 and 5, else floor) and shifts
	localparam logic [6:0]  RCP_400Y = 7'd114;    // s = 24, may come out one low
	localparam logic [7:0]  RCP_4Y   = 8'd179;    // s = 18, may come out one low
	localparam logic [3:0]  RCP_5M   = 4'd13;     // s = 11, may come out one low
	localparam logic [13:0] RCP_25   = 14'd10486; // s = 18, exact below 43690
	localparam logic [7:0]  RCP_5    = 8'd205;    // s = 10, exact below 1024

	typedef struct packed {
		logic        cmd;
		logic [13:0] in_year;
		logic [3:0]  in_month;
		logic [4:0]  in_day;
		logic [22:0] in_day_number;
	} req_t;

	typedef struct packed {
		logic [22:0] out_day_number;
		logic [13:0] out_year;
		logic [3:0]  out_month;
		logic [4:0]  out_day;
		logic [2:0]  weekday;
		logic        business_day;
		logic        leap_year;
		logic        range_error;
	} rsp_t;

	// Item context carried down the pipeline
	typedef struct packed {
		logic        cmd;
		logic        err;
		logic [22:0] jdn;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} ctx_t;

	// Days before the shifted month m (March = 0): (153 * m + 2) / 5
	function automatic logic [8:0] month_days(input logic [3:0] m);
		logic [8:0] v;
		unique case (m)
			4'd0:    v = 9'd0;
			4'd1:    v = 9'd31;
			4'd2:    v = 9'd61;
			4'd3:    v = 9'd92;
			4'd4:    v = 9'd122;
			4'd5:    v = 9'd153;
			4'd6:    v = 9'd184;
			4'd7:    v = 9'd214;
			4'd8:    v = 9'd245;
			4'd9:    v = 9'd275;
			4'd10:   v = 9'd306;
			4'd11:   v = 9'd337;
			4'd12:   v = 9'd367;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

endpackage

[rtl/calendar_day_number_converter_top.sv]
// Calendar date <-> Julian day number converter, 13-stage pipeline.
// Depends on cdn_pkg for request/response types, constants and month table.
//
//  Channel   | Dir | Signals          | Transfer
//  ----------+-----+------------------+-------------------------------------
//  request   | in  | start, busy, req | taken at edge with start && !busy
//  response  | out | done, rsp        | rsp valid for the one cycle done is high
//
// A new request is taken every cycle.
// Depth comes from the day-number-to-date path: three reciprocal divides, each a
// multiply, a remainder and a one-step correction, then the leap and weekday check.
// busy stays low: nothing inside ever holds off a request.
// Reset clears only the stage valid bits; data registers load freely.
// The receiver cannot stall, so each response leaves the last stage directly.
module calendar_day_number_converter_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cdn_pkg::req_t req,
	output logic          done,
	output cdn_pkg::rsp_t rsp
);
	import cdn_pkg::*;

	// Stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic vld_s8, vld_s9, vld_s10, vld_s11, vld_s12, vld_s13;

	// Item context
	ctx_t ctx_s1, ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6, ctx_s7;
	ctx_t ctx_s8, ctx_s9, ctx_s10, ctx_s11, ctx_s12;

	// Forward path registers
	logic [14:0] y_s1;
	logic [8:0]  mdays_s1, mdays_s2;
	logic [12:0] q_s2;
	logic [8:0]  c25_s2, c25_s3;
	logic [23:0] y365_s2, base_s3;

	// Reverse path registers
	logic [23:0] x_s1, x_s2;
	logic [6:0]  cest_s2, cest_s3;
	logic [18:0] rraw_s3;
	logic [6:0]  c_s4, c_s5, c_s6, c_s7, c_s8, c_s9, c_s10;
	logic [17:0] t_s4, t_s5;
	logic [7:0]  yest_s5, yest_s6;
	logic [11:0] d2raw_s6;
	logic [7:0]  yy_s7, yy_s8, yy_s9, yy_s10;
	logic [10:0] u_s7, u_s8;
	logic [3:0]  mest_s8, mest_s9;
	logic [8:0]  ddraw_s9;
	logic [3:0]  mm_s10;
	logic [7:0]  dd_s10;

	// Check stage registers
	logic [9:0]  yq_s12;
	logic [5:0]  dsum_s12;
	rsp_t        rsp_s13;

	// Combinational stage results
	logic        acc;
	logic        early_c;
	logic [3:0]  m_c;
	logic [14:0] y_c;
	logic [24:0] x_c;
	logic        err_c;
	ctx_t        ctx1_c;
	logic [26:0] p25_c;
	logic [30:0] p400_c;
	logic [24:0] r400_c;
	logic [23:0] jdn0_c;
	logic [18:0] r_c;
	logic        r_carry_c;
	ctx_t        ctx4_c;
	logic [25:0] p4y_c;
	logic [18:0] d2_full_c;
	logic        d2_carry_c;
	logic [11:0] d2_c;
	logic [8:0]  d2q_c;
	logic [14:0] p5m_c;
	logic [10:0] dd_full_c;
	logic        dd_carry_c;
	logic [8:0]  dd_c;
	logic [15:0] p5_c;
	logic [4:0]  day_c;
	logic [3:0]  month_c;
	logic [13:0] year_c;
	ctx_t        ctx11_c;
	logic [27:0] pyq_c;
	logic [23:0] jdn24_c;
	logic [5:0]  dsum_c;
	logic        z25_c;
	logic [3:0]  fold_c;
	logic [3:0]  wv_c;
	logic [2:0]  wr_c;
	rsp_t        rsp_c;

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// Stage 1: shift the month to March-based, bias the year, form 4j - 1, range check
	always_comb begin
		early_c = (req.in_month <= 4'd2);
		m_c     = early_c ? (req.in_month + 4'd9) : (req.in_month - 4'd3);
		y_c     = 15'(req.in_year) + YEAR_BIAS - 15'(early_c);
		x_c     = {req.in_day_number, 2'b00} - X_OFFSET;
		err_c   = (req.cmd == CMD_JDN_TO_DATE) &&
			((req.in_day_number < JDN_MIN) || (req.in_day_number > JDN_MAX));
		ctx1_c.cmd   = req.cmd;
		ctx1_c.err   = err_c;
		ctx1_c.jdn   = req.in_day_number;
		ctx1_c.year  = req.in_year;
		ctx1_c.month = req.in_month;
		ctx1_c.day   = req.in_day;
	end

	// Stage 2: year / 100 via reciprocal, 365 * y, first estimate of 400-year count
	always_comb begin
		p25_c  = 27'(y_s1[14:2]) * 27'(RCP_25);
		p400_c = 31'(x_s1) * 31'(RCP_400Y);
	end

	// Stage 3: remainder within the 400-year cycle
	assign r400_c = 25'(x_s2) - 25'(cest_s2) * 25'(DAYS_400Y);

	// Stage 4: finish the forward sum, correct the 400-year estimate
	always_comb begin
		jdn0_c    = base_s3 - 24'(c25_s3) + 24'(c25_s3[8:2]) - EPOCH_OFS;
		r_carry_c = (rraw_s3 >= DAYS_400Y);
		r_c       = r_carry_c ? (rraw_s3 - DAYS_400Y) : rraw_s3;
		ctx4_c    = ctx_s3;
		if (ctx_s3.cmd == CMD_DATE_TO_JDN) begin
			ctx4_c.jdn = jdn0_c[22:0];
		end
	end

	// Stage 5: estimate years within the century
	assign p4y_c = 26'(t_s4) * 26'(RCP_4Y);

	// Stage 6: remainder within the 4-year cycle
	assign d2_full_c = 19'(t_s5) - 19'(yest_s5) * 19'(DAYS_4Y);

	// Stage 7: correct the year estimate, form 5 * day-of-year + 2
	always_comb begin
		d2_carry_c = (d2raw_s6 >= DAYS_4Y);
		d2_c       = d2_carry_c ? (d2raw_s6 - DAYS_4Y) : d2raw_s6;
		d2q_c      = d2_c[10:2];
	end

	// Stage 8: estimate the month
	assign p5m_c = 15'(u_s7) * 15'(RCP_5M);

	// Stage 9: remainder within the month
	assign dd_full_c = u_s8 - 11'(mest_s8) * 11'(DAYS_5M);

	// Stage 10: correct the month estimate
	always_comb begin
		dd_carry_c = (ddraw_s9 >= DAYS_5M);
		dd_c       = dd_carry_c ? (ddraw_s9 - DAYS_5M) : ddraw_s9;
	end

	// Stage 11: assemble year, month and day; clear them on a range error
	always_comb begin
		p5_c    = 16'(dd_s10) * 16'(RCP_5);
		day_c   = 5'(p5_c[15:10]) + 5'd1;
		month_c = (mm_s10 < 4'd10) ? (mm_s10 + 4'd3) : (mm_s10 - 4'd9);
		year_c  = 14'(c_s10) * 14'd100 + 14'(yy_s10) + 14'(mm_s10 >= 4'd10);
		ctx11_c = ctx_s10;
		if (ctx_s10.cmd == CMD_JDN_TO_DATE) begin
			if (ctx_s10.err) begin
				ctx11_c.year  = '0;
				ctx11_c.month = '0;
				ctx11_c.day   = '0;
			end else begin
				ctx11_c.year  = year_c;
				ctx11_c.month = month_c;
				ctx11_c.day   = day_c;
			end
		end
	end

	// Stage 12: year / 25 for the leap test, octal digit sum of the day number
	always_comb begin
		pyq_c   = 28'(ctx_s11.year) * 28'(RCP_25);
		jdn24_c = {1'b0, ctx_s11.jdn};
		dsum_c  = '0;
		for (int i = 0; i < 8; i++) begin
			dsum_c = dsum_c + 6'(jdn24_c[3*i +: 3]);
		end
	end

	// Stage 13: leap flag, weekday as (jdn + 1) mod 7 + 1
	always_comb begin
		z25_c  = ((15'(yq_s12) * 15'd25) == 15'(ctx_s12.year));
		fold_c = 4'(dsum_s12[5:3]) + 4'(dsum_s12[2:0]) + 4'd1;
		wv_c   = fold_c;
		priority if (wv_c >= 4'd14) begin
			wr_c = 3'(wv_c - 4'd14);
		end else if (wv_c >= 4'd7) begin
			wr_c = 3'(wv_c - 4'd7);
		end else begin
			wr_c = 3'(wv_c);
		end
		rsp_c.out_day_number = ctx_s12.jdn;
		rsp_c.out_year       = ctx_s12.year;
		rsp_c.out_month      = ctx_s12.month;
		rsp_c.out_day        = ctx_s12.day;
		rsp_c.weekday        = wr_c + 3'd1;
		rsp_c.business_day   = (wr_c != 3'd0) && (wr_c != 3'd6);
		rsp_c.leap_year      = !ctx_s12.err && (ctx_s12.year[1:0] == 2'b00) &&
			(!z25_c || (ctx_s12.year[3:0] == 4'd0));
		rsp_c.range_error    = ctx_s12.err;
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
		end else begin
			vld_s1  <= acc;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
		end
	end

	// Advance data; no reset on payload
	always_ff @(posedge clk) begin
		ctx_s1   <= ctx1_c;
		y_s1     <= y_c;
		mdays_s1 <= month_days(m_c);
		x_s1     <= x_c[23:0];

		ctx_s2   <= ctx_s1;
		q_s2     <= y_s1[14:2];
		c25_s2   <= p25_c[26:18];
		y365_s2  <= 24'(y_s1) * 24'd365;
		mdays_s2 <= mdays_s1;
		x_s2     <= x_s1;
		cest_s2  <= p400_c[30:24];

		ctx_s3   <= ctx_s2;
		base_s3  <= y365_s2 + 24'(q_s2) + 24'(mdays_s2) + 24'(ctx_s2.day);
		c25_s3   <= c25_s2;
		rraw_s3  <= r400_c[18:0];
		cest_s3  <= cest_s2;

		ctx_s4   <= ctx4_c;
		c_s4     <= cest_s3 + 7'(r_carry_c);
		t_s4     <= {r_c[17:2], 2'b11};

		ctx_s5   <= ctx_s4;
		c_s5     <= c_s4;
		t_s5     <= t_s4;
		yest_s5  <= p4y_c[25:18];

		ctx_s6   <= ctx_s5;
		c_s6     <= c_s5;
		yest_s6  <= yest_s5;
		d2raw_s6 <= d2_full_c[11:0];

		ctx_s7   <= ctx_s6;
		c_s7     <= c_s6;
		yy_s7    <= yest_s6 + 8'(d2_carry_c);
		u_s7     <= 11'({d2q_c, 2'b00}) + 11'(d2q_c) + 11'd2;

		ctx_s8   <= ctx_s7;
		c_s8     <= c_s7;
		yy_s8    <= yy_s7;
		u_s8     <= u_s7;
		mest_s8  <= p5m_c[14:11];

		ctx_s9   <= ctx_s8;
		c_s9     <= c_s8;
		yy_s9    <= yy_s8;
		mest_s9  <= mest_s8;
		ddraw_s9 <= dd_full_c[8:0];

		ctx_s10  <= ctx_s9;
		c_s10    <= c_s9;
		yy_s10   <= yy_s9;
		mm_s10   <= mest_s9 + 4'(dd_carry_c);
		dd_s10   <= dd_c[7:0];

		ctx_s11  <= ctx11_c;

		ctx_s12  <= ctx_s11;
		yq_s12   <= pyq_c[27:18];
		dsum_s12 <= dsum_c;

		rsp_s13  <= rsp_c;
	end

	assign done = vld_s13;
	assign rsp  = rsp_s13;

	// Every response has a matching request that entered the first stage earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_s1, 12))
		else $error("response without a matching request");

	// An out-of-range day number clears the date fields and the leap flag
	a_err_clear: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.range_error |-> rsp.out_year == '0 && rsp.out_month == '0 &&
			rsp.out_day == '0 && !rsp.leap_year)
		else $error("range error with date fields set");

	// A range error only flags day numbers outside the window
	a_err_window: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.range_error |->
			(rsp.out_day_number < JDN_MIN) || (rsp.out_day_number > JDN_MAX))
		else $error("range error inside supported window");

	// A leap year is a multiple of four
	a_leap_div4: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.leap_year |-> rsp.out_year[1:0] == 2'b00)
		else $error("leap flag on a year not divisible by four");

	// Weekday is never zero and the business flag agrees with it
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.weekday != 3'd0) &&
			(rsp.business_day == ((rsp.weekday != 3'd1) && (rsp.weekday != 3'd7))))
		else $error("weekday and business flag disagree");

endmodule
